// ===== rtl/segtree_pkg.sv =====
package segtree_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_LEAVES = 1024;
  localparam int LG_MAX     = $clog2(MAX_LEAVES);
  localparam int NODE_COUNT = 2 * MAX_LEAVES;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int LG_W       = $clog2(LG_MAX + 1);
  localparam int POS_W      = LG_MAX;
  localparam int SPAN_W     = LG_MAX + 1;
  localparam int MODE_W     = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_WORD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE  = 2'd2;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LEAF,
    S_UP,
    S_QUERY,
    S_DONE
  } state_t;

  // Sum wraps; min and max compare signed. Mode three acts as sum.
  function automatic logic [DATA_WIDTH-1:0] join_words(
    input logic [MODE_W-1:0]     mode,
    input logic [DATA_WIDTH-1:0] a,
    input logic [DATA_WIDTH-1:0] b
  );
    logic a_less;
    logic [DATA_WIDTH-1:0] y;
    a_less = $signed(a) < $signed(b);
    case (mode)
      MODE_MIN: y = a_less ? a : b;
      MODE_MAX: y = a_less ? b : a;
      default:  y = a + b;
    endcase
    return y;
  endfunction

  // log2 of the padded leaf count: smallest power of two at or above the
  // requested size, clamped to MAX_LEAVES, at least one leaf.
  function automatic logic [LG_W-1:0] leaf_log(input logic [SPAN_W-1:0] size);
    logic [SPAN_W-1:0] want;
    logic [LG_W-1:0]   lg;
    want = (size > SPAN_W'(MAX_LEAVES)) ? SPAN_W'(MAX_LEAVES) : size;
    lg   = '0;
    for (int i = 0; i < LG_MAX; i++) begin
      if (want > (SPAN_W'(1) << i)) lg = LG_W'(i + 1);
    end
    return lg;
  endfunction

endpackage

// ===== rtl/segment_tree_range_query.sv =====
// Channel  Direction  Handshake                  Word
// in       sink       in_valid / in_ready        cmd, position, new_value, range_lo, range_hi
// out      source     out_valid / out_ready      answer, status
// cfg      sink       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item at a time: in_ready is high only while idle.
// Update: leaf write, then one combine per ancestor.
// Query: one child node classified per cycle.
// Clear: every node rewritten, one node written per cycle; a rejected word is answered with status set.
// After reset a clearing pass zeroes all 2048 nodes with in_ready low; cfg writes
// are taken throughout. A result waits in a holding stage while out is stalled.
module segment_tree_range_query
  import segtree_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [POS_W-1:0]      position,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic [POS_W-1:0]      range_lo,
  input  logic [SPAN_W-1:0]     range_hi,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] answer,
  output logic                  status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  // configuration
  logic [MODE_W-1:0]     combine_mode;
  logic [DATA_WIDTH-1:0] neutral_word;
  logic [SPAN_W-1:0]     size_in_use;

  // control
  state_t state, state_next;
  logic [LG_W-1:0]   lg, lg_next;
  logic [ADDR_W-1:0] sweep_cnt, sweep_cnt_next;
  logic              sweep_zero, sweep_zero_next;

  // update path
  logic [ADDR_W-1:0]     x, x_next;
  logic [DATA_WIDTH-1:0] v, v_next;

  // query path
  logic [POS_W-1:0]      q_lo, q_lo_next;
  logic [SPAN_W-1:0]     q_hi, q_hi_next;
  logic [LG_W-1:0]       q_depth, q_depth_next;
  logic                  q_root, q_root_next;
  logic                  q_active, q_active_next;
  logic [1:0]            q_j, q_j_next;
  logic [POS_W-1:0]      fl, fl_next, fr, fr_next;
  logic                  fr_valid, fr_valid_next;
  logic [POS_W-1:0]      nl, nl_next, nr, nr_next;
  logic                  nl_valid, nl_valid_next, nr_valid, nr_valid_next;
  logic                  pend_valid, pend_valid_next;
  logic                  pend_mem, pend_mem_next;
  logic [DATA_WIDTH-1:0] acc, acc_next;
  logic                  acc_valid, acc_valid_next;

  // result holding and output stage
  logic [DATA_WIDTH-1:0] res_answer, res_answer_next;
  logic                  res_status, res_status_next;
  logic                  out_valid_next;
  logic [DATA_WIDTH-1:0] answer_next;
  logic                  status_next;

  // node memory
  logic [DATA_WIDTH-1:0] node_mem [NODE_COUNT];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, rdata;

  // shared combine unit
  logic [DATA_WIDTH-1:0] join_a, join_b, join_y;

  // helpers
  logic [LG_W-1:0]   lg_cur;
  logic [SPAN_W-1:0] nw_cur;
  logic [ADDR_W-1:0] px;
  logic [LG_W-1:0]   sh;
  logic [POS_W-1:0]  par_k, cand_k;
  logic [SPAN_W-1:0] seg_lo, seg_hi;
  logic [ADDR_W-1:0] cand_addr;
  logic              cand_disjoint, cand_full, cand_last;
  logic [DATA_WIDTH-1:0] opnd;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE);

  assign join_y = join_words(combine_mode, join_a, join_b);

  assign lg_cur = leaf_log(size_in_use);
  assign nw_cur = SPAN_W'(1) << lg_cur;
  assign px     = (x - ADDR_W'(1)) >> 1;

  // child classification for the query walk
  assign sh        = lg - q_depth;
  assign par_k     = q_j[1] ? fr : fl;
  assign cand_k    = q_root ? '0 : {par_k[POS_W-2:0], q_j[0]};
  assign seg_lo    = {1'b0, cand_k} << sh;
  assign seg_hi    = seg_lo + (SPAN_W'(1) << sh);
  assign cand_addr = ((ADDR_W'(1) << q_depth) - ADDR_W'(1)) + ADDR_W'(cand_k);
  assign cand_disjoint = (seg_lo >= q_hi) || ({1'b0, q_lo} >= seg_hi);
  assign cand_full     = (seg_lo >= {1'b0, q_lo}) && (seg_hi <= q_hi);
  assign cand_last     = q_root || (q_j == 2'd3) || ((q_j == 2'd1) && !fr_valid);
  assign opnd          = pend_mem ? rdata : neutral_word;

  always_ff @(posedge clk) begin
    if (mem_we) node_mem[mem_waddr] <= mem_wdata;
    rdata <= node_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_SUM;
      neutral_word <= '0;
      size_in_use  <= SPAN_W'(MAX_LEAVES);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COMBINE_MODE: combine_mode <= cfg_data[MODE_W-1:0];
        REG_NEUTRAL_WORD: neutral_word <= cfg_data;
        REG_SIZE_IN_USE:  size_in_use  <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      sweep_zero <= 1'b1;
      out_valid  <= 1'b0;
      q_active   <= 1'b0;
      pend_valid <= 1'b0;
      acc_valid  <= 1'b0;
      nl_valid   <= 1'b0;
      nr_valid   <= 1'b0;
      fr_valid   <= 1'b0;
      q_root     <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_cnt  <= sweep_cnt_next;
      sweep_zero <= sweep_zero_next;
      out_valid  <= out_valid_next;
      q_active   <= q_active_next;
      pend_valid <= pend_valid_next;
      acc_valid  <= acc_valid_next;
      nl_valid   <= nl_valid_next;
      nr_valid   <= nr_valid_next;
      fr_valid   <= fr_valid_next;
      q_root     <= q_root_next;
    end
    lg         <= lg_next;
    x          <= x_next;
    v          <= v_next;
    q_lo       <= q_lo_next;
    q_hi       <= q_hi_next;
    q_depth    <= q_depth_next;
    q_j        <= q_j_next;
    fl         <= fl_next;
    fr         <= fr_next;
    nl         <= nl_next;
    nr         <= nr_next;
    pend_mem   <= pend_mem_next;
    acc        <= acc_next;
    res_answer <= res_answer_next;
    res_status <= res_status_next;
    answer     <= answer_next;
    status     <= status_next;
  end

  always_comb begin
    state_next      = state;
    lg_next         = lg;
    sweep_cnt_next  = sweep_cnt;
    sweep_zero_next = sweep_zero;
    x_next          = x;
    v_next          = v;
    q_lo_next       = q_lo;
    q_hi_next       = q_hi;
    q_depth_next    = q_depth;
    q_root_next     = q_root;
    q_active_next   = q_active;
    q_j_next        = q_j;
    fl_next         = fl;
    fr_next         = fr;
    fr_valid_next   = fr_valid;
    nl_next         = nl;
    nr_next         = nr;
    nl_valid_next   = nl_valid;
    nr_valid_next   = nr_valid;
    pend_valid_next = pend_valid;
    pend_mem_next   = pend_mem;
    acc_next        = acc;
    acc_valid_next  = acc_valid;
    res_answer_next = res_answer;
    res_status_next = res_status;
    out_valid_next  = out_valid && !out_ready;
    answer_next     = answer;
    status_next     = status;
    mem_we          = 1'b0;
    mem_waddr       = x;
    mem_wdata       = v;
    mem_raddr       = '0;
    join_a          = v;
    join_b          = rdata;

    unique case (state)
      S_SWEEP: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_cnt;
        mem_wdata      = sweep_zero ? '0 : neutral_word;
        sweep_cnt_next = sweep_cnt + ADDR_W'(1);
        if (sweep_cnt == ADDR_W'(NODE_COUNT - 1)) begin
          if (sweep_zero) begin
            state_next = S_IDLE;
          end else begin
            res_answer_next = '0;
            res_status_next = 1'b0;
            state_next      = S_DONE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          lg_next         = lg_cur;
          res_answer_next = '0;
          res_status_next = 1'b1;
          state_next      = S_DONE;
          unique case (cmd)
            CMD_UPDATE: begin
              if ({1'b0, position} < nw_cur) begin
                x_next          = ADDR_W'(nw_cur - SPAN_W'(1)) + ADDR_W'(position);
                v_next          = new_value;
                res_status_next = 1'b0;
                state_next      = S_LEAF;
              end
            end
            CMD_QUERY: begin
              if (!({1'b0, range_lo} >= nw_cur || range_hi > nw_cur ||
                    {1'b0, range_lo} >= range_hi)) begin
                q_lo_next       = range_lo;
                q_hi_next       = range_hi;
                q_depth_next    = '0;
                q_root_next     = 1'b1;
                q_active_next   = 1'b1;
                q_j_next        = '0;
                nl_valid_next   = 1'b0;
                nr_valid_next   = 1'b0;
                fr_valid_next   = 1'b0;
                pend_valid_next = 1'b0;
                acc_valid_next  = 1'b0;
                res_status_next = 1'b0;
                state_next      = S_QUERY;
              end
            end
            CMD_CLEAR: begin
              sweep_cnt_next  = '0;
              sweep_zero_next = 1'b0;
              state_next      = S_SWEEP;
            end
            default: ;
          endcase
        end
      end

      S_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = x;
        mem_wdata = v;
        if (x == '0) begin
          state_next = S_DONE;
        end else begin
          mem_raddr  = x[0] ? x + ADDR_W'(1) : x - ADDR_W'(1);
          state_next = S_UP;
        end
      end

      S_UP: begin
        // combine with the sibling read last cycle, write the parent
        join_a    = v;
        join_b    = rdata;
        mem_we    = 1'b1;
        mem_waddr = px;
        mem_wdata = join_y;
        v_next    = join_y;
        x_next    = px;
        if (px == '0) begin
          state_next = S_DONE;
        end else begin
          mem_raddr = px[0] ? px + ADDR_W'(1) : px - ADDR_W'(1);
        end
      end

      S_QUERY: begin
        join_a          = acc;
        join_b          = opnd;
        pend_valid_next = 1'b0;
        if (pend_valid) begin
          acc_next       = acc_valid ? join_y : opnd;
          acc_valid_next = 1'b1;
        end
        if (q_active) begin
          if (cand_disjoint) begin
            pend_valid_next = 1'b1;
            pend_mem_next   = 1'b0;
          end else if (cand_full) begin
            mem_raddr       = cand_addr;
            pend_valid_next = 1'b1;
            pend_mem_next   = 1'b1;
          end else if (!nl_valid) begin
            nl_next       = cand_k;
            nl_valid_next = 1'b1;
          end else begin
            nr_next       = cand_k;
            nr_valid_next = 1'b1;
          end
          if (cand_last) begin
            // descend one level with the partial children as the new frontier
            if (nl_valid_next) begin
              fl_next       = nl_next;
              fr_next       = nr_next;
              fr_valid_next = nr_valid_next;
              nl_valid_next = 1'b0;
              nr_valid_next = 1'b0;
              q_depth_next  = q_depth + LG_W'(1);
              q_j_next      = '0;
              q_root_next   = 1'b0;
            end else begin
              q_active_next = 1'b0;
            end
          end else begin
            q_j_next = q_j + 2'd1;
          end
        end else if (!pend_valid) begin
          res_answer_next = acc;
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          answer_next    = res_answer;
          status_next    = res_status;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
